### hdl/assert_macros.svh
// Assertion macros used by the top level of the option parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/tcpop_pkg.sv
// Types and constants shared by the TCP option parser modules.
package tcpop_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_OVERRUN   = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_e;

  localparam logic [7:0] OPT_EOL = 8'd0;
  localparam logic [7:0] OPT_NOP = 8'd1;
  localparam logic [7:0] OPT_MSS = 8'd2;
  localparam logic [7:0] OPT_TS  = 8'd8;

  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_OPT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [3:0] data_offset;
    logic       ack_bit;
    logic [7:0] opt_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] mss_value;
    logic        mss_updated;
    logic [31:0] echo_value;
    logic        echo_updated;
  } result_t;

  // Handshake between the input register and the parser core.
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

### hdl/tcpop_in_stage.sv
// Input register of the TCP option parser.
module tcpop_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcpop_pkg::in_word_t in_word_i,
  input  logic                take_i,
  output logic                word_valid_o,
  output tcpop_pkg::in_word_t word_o
);
  import tcpop_pkg::*;

  logic     valid_q;
  in_word_t word_q;
  logic     load;

  assign in_ready_o   = !valid_q || take_i;
  assign load         = in_valid_i && in_ready_o;
  assign word_valid_o = valid_q;
  assign word_o       = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

endmodule

### hdl/tcpop_core.sv
// Parser state and the per-word step logic of the TCP option parser.
module tcpop_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 timestamps_valid_i,
  input  tcpop_pkg::stage_ctl_t ctl_i,
  input  tcpop_pkg::in_word_t  word_i,
  output logic                 res_valid_o,
  output tcpop_pkg::result_t   res_o
);
  import tcpop_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_KIND = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [5:0]  left_q, left_d;
  logic [7:0]  code_q, code_d;
  logic [5:0]  len_q, len_d;
  logic [5:0]  idx_q, idx_d;
  logic [31:0] gather_q, gather_d;
  logic [15:0] mss_q, mss_d;
  logic [31:0] echo_q, echo_d;
  logic        ack_q, ack_d;
  logic        mss_upd_q, mss_upd_d;
  logic        echo_upd_q, echo_upd_d;

  logic        res_valid;
  status_e     res_status;
  logic [5:0]  hdr_bytes;
  logic [7:0]  b;

  assign b         = word_i.opt_byte;
  assign hdr_bytes = {word_i.data_offset, 2'b00} - 6'd20;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    code_d     = code_q;
    len_d      = len_q;
    idx_d      = idx_q;
    gather_d   = gather_q;
    mss_d      = mss_q;
    echo_d     = echo_q;
    ack_d      = ack_q;
    mss_upd_d  = mss_upd_q;
    echo_upd_d = echo_upd_q;
    res_valid  = 1'b0;
    res_status = ST_OK;

    if (ctl_i.valid && ctl_i.take) begin
      if (word_i.kind == KIND_HDR) begin
        // A new header abandons whatever parse was running.
        ack_d      = word_i.ack_bit;
        mss_upd_d  = 1'b0;
        echo_upd_d = 1'b0;
        code_d     = '0;
        len_d      = '0;
        idx_d      = '0;
        gather_d   = '0;
        if (word_i.data_offset < 4'd5) begin
          left_d     = '0;
          res_valid  = 1'b1;
          res_status = ST_TOO_SHORT;
          phase_d    = PH_IDLE;
        end else begin
          left_d = hdr_bytes;
          if (hdr_bytes == 6'd0) begin
            res_valid = 1'b1;
            phase_d   = PH_IDLE;
          end else begin
            phase_d = PH_KIND;
          end
        end
      end else begin
        case (phase_q)
          PH_KIND: begin
            if (b == OPT_NOP) begin
              left_d = left_q - 6'd1;
              if (left_d == 6'd0) begin
                res_valid = 1'b1;
                phase_d   = PH_IDLE;
              end
            end else if (b == OPT_EOL) begin
              res_valid = 1'b1;
              phase_d   = PH_IDLE;
            end else if (left_q < 6'd2) begin
              // No room left for the length byte.
              res_valid  = 1'b1;
              res_status = ST_OVERRUN;
              phase_d    = PH_IDLE;
            end else begin
              code_d  = b;
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (b < 8'd2) begin
              res_valid  = 1'b1;
              res_status = ST_BAD_LEN;
              phase_d    = PH_IDLE;
            end else if (b > {2'b00, left_q}) begin
              res_valid  = 1'b1;
              res_status = ST_OVERRUN;
              phase_d    = PH_IDLE;
            end else begin
              left_d   = left_q - b[5:0];
              len_d    = b[5:0];
              idx_d    = '0;
              gather_d = '0;
              if (b == 8'd2) begin
                if (left_d == 6'd0) begin
                  res_valid = 1'b1;
                  phase_d   = PH_IDLE;
                end else begin
                  phase_d = PH_KIND;
                end
              end else begin
                phase_d = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            gather_d = {gather_q[23:0], b};
            if (code_q == OPT_MSS && idx_q == 6'd1) begin
              mss_d     = gather_d[15:0];
              mss_upd_d = 1'b1;
            end
            if (code_q == OPT_TS && idx_q == 6'd3 && ack_q && timestamps_valid_i) begin
              echo_d     = gather_d;
              echo_upd_d = 1'b1;
            end
            idx_d = idx_q + 6'd1;
            if (({1'b0, idx_d} + 7'd2) >= {1'b0, len_q}) begin
              if (left_q == 6'd0) begin
                res_valid = 1'b1;
                phase_d   = PH_IDLE;
              end else begin
                phase_d = PH_KIND;
              end
            end
          end
          default: begin
            // Idle: stray option bytes are dropped.
          end
        endcase
      end
    end
  end

  assign res_valid_o = res_valid;
  assign res_o = '{status:       res_status,
                   mss_value:    mss_d,
                   mss_updated:  mss_upd_d,
                   echo_value:   echo_d,
                   echo_updated: echo_upd_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      left_q     <= '0;
      code_q     <= '0;
      len_q      <= '0;
      idx_q      <= '0;
      gather_q   <= '0;
      mss_q      <= '0;
      echo_q     <= '0;
      ack_q      <= 1'b0;
      mss_upd_q  <= 1'b0;
      echo_upd_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      left_q     <= left_d;
      code_q     <= code_d;
      len_q      <= len_d;
      idx_q      <= idx_d;
      gather_q   <= gather_d;
      mss_q      <= mss_d;
      echo_q     <= echo_d;
      ack_q      <= ack_d;
      mss_upd_q  <= mss_upd_d;
      echo_upd_q <= echo_upd_d;
    end
  end

endmodule

### hdl/tcpop_out_stage.sv
// Result register of the TCP option parser.
module tcpop_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tcpop_pkg::result_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcpop_pkg::result_t res_o
);
  import tcpop_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

### hdl/tcp_option_parser_top.sv
// Top level of the TCP option parser: input register, parser core, result register.
//
// The block walks the option area of a TCP header, one word per cycle unless
// stalled. A header word (kind 0) carries the data offset and the ACK flag; each
// following option word (kind 1) carries one byte of the option area. A result
// word is produced when a parse ends, none for one abandoned by a new header:
// status, the stored peer MSS and the stored timestamp echo value, each with a
// flag saying whether this segment updated it; other words update the parser state.
// The in and out channels use valid/ready; the cfg channel writes the
// timestamps-enable register and is always ready. Write it only while the
// block is idle.
// An accepted word waits in the input register until the parser core steps it;
// any result of the step goes straight into the result register.
// Throughput: one word per cycle while the result register has room, set by the
// single registered step of the parser core between the input and result registers.
// When the receiver stalls, the result register holds its word; the input
// register then fills and in_ready_o drops until the result is taken.
// Reset clears the parser state, the stored MSS and echo values, the enable
// register and both stage valids; the block accepts words straight away.
`include "assert_macros.svh"

module tcp_option_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        timestamps_valid_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [3:0]  data_offset_i,
  input  logic        ack_bit_i,
  input  logic [7:0]  opt_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] mss_value_o,
  output logic        mss_updated_o,
  output logic [31:0] echo_value_o,
  output logic        echo_updated_o
);
  import tcpop_pkg::*;

  logic       ts_en_q;
  in_word_t   in_word;
  in_word_t   s1_word;
  logic       s1_valid;
  logic       out_free;
  stage_ctl_t ctl;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // The enable register is always ready to take a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      ts_en_q <= timestamps_valid_i;
    end
  end

  assign in_word = '{kind:        kind_i,
                     data_offset: data_offset_i,
                     ack_bit:     ack_bit_i,
                     opt_byte:    opt_byte_i};

  // A buffered word steps the parser only when its result, if any, has a place.
  assign ctl.valid = s1_valid;
  assign ctl.take  = s1_valid && out_free;

  tcpop_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word),
    .take_i       (ctl.take),
    .word_valid_o (s1_valid),
    .word_o       (s1_word)
  );

  tcpop_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .timestamps_valid_i (ts_en_q),
    .ctl_i              (ctl),
    .word_i             (s1_word),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  tcpop_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign status_o       = out_res.status;
  assign mss_value_o    = out_res.mss_value;
  assign mss_updated_o  = out_res.mss_updated;
  assign echo_value_o   = out_res.echo_value;
  assign echo_updated_o = out_res.echo_updated;

  // A result is only produced when the result register can take it.
  `ASSERT_IMP(a_res_has_room, clk_i, rst_ni, res_valid, out_free)

  // A buffered word that is not stepped stays buffered.
  `ASSERT_NEXT(a_s1_held, clk_i, rst_ni, s1_valid && !ctl.take, s1_valid)

  // A too-short header resets the per-segment update flags.
  `ASSERT_IMP(a_short_no_upd, clk_i, rst_ni,
              out_valid_o && (status_o == ST_TOO_SHORT),
              !mss_updated_o && !echo_updated_o)

endmodule

### test/tb_tcp_option_parser_top.sv
// Self-checking testbench for the TCP option parser: segment stimulus, parse predictor, checker.
module tb_tcp_option_parser_top;
  import tcpop_pkg::*;

  // Generous ceiling on the run, leaving a wide margin over the slowest correct run of
  // roughly 2500 words.
  localparam int CYCLE_LIMIT = 400000;
  // A taken word waits in the input register before it is stepped, and its result is registered.
  // The settle time after the last result covers a word that produces no result.
  localparam int SETTLE_CYCLES = 4;
  // Cap on printed mismatch lines. Every mismatch is still counted.
  localparam int PRINT_CAP = 100;

  // Parser walk states of the predictor.
  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_KIND,
    WALK_LEN,
    WALK_BODY
  } walk_e;

  // Every input of the block has a known value from time zero.
  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        cfg_valid_i        = 1'b0;
  logic        timestamps_valid_i = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        kind_i             = 1'b0;
  logic [3:0]  data_offset_i      = '0;
  logic        ack_bit_i          = 1'b0;
  logic [7:0]  opt_byte_i         = '0;
  logic        out_ready_i        = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [15:0] mss_value_o;
  logic        mss_updated_o;
  logic [31:0] echo_value_o;
  logic        echo_updated_o;

  tcp_option_parser_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .timestamps_valid_i (timestamps_valid_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .data_offset_i      (data_offset_i),
    .ack_bit_i          (ack_bit_i),
    .opt_byte_i         (opt_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .mss_value_o        (mss_value_o),
    .mss_updated_o      (mss_updated_o),
    .echo_value_o       (echo_value_o),
    .echo_updated_o     (echo_updated_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Words waiting to be sent, and results that the predictor says must still arrive.
  in_word_t words_to_send[$];
  result_t  results_due[$];

  // Outputs of the block are sampled at the falling edge, where everything has settled, and
  // the handshakes are then judged at the next rising edge from these copies. No decision
  // therefore depends on the order in which processes run at the rising edge.
  logic     in_ready_s  = 1'b0;
  logic     cfg_ready_s = 1'b0;
  logic     out_valid_s = 1'b0;
  result_t  seen_result = '0;

  // Set at the rising edge on which the block takes a word; the word is stepped through the
  // predictor at the following falling edge.
  logic     word_taken = 1'b0;
  in_word_t taken_word = '0;

  // Idle behaviour of each side, changed between phases of the run.
  int       gap_pct   = 0;
  int       stall_pct = 0;
  logic     calm      = 1'b0;
  int       gap_left  = 0;
  int       stall_left = 0;

  int       cycle      = 0;
  int       mismatches = 0;

  // Predictor state, mirroring the parser after reset.
  walk_e       walk         = WALK_IDLE;
  logic [5:0]  area_left    = '0;
  logic [7:0]  cur_code     = '0;
  logic [7:0]  cur_len      = '0;
  logic [7:0]  body_pos     = '0;
  logic [31:0] body_bits    = '0;
  logic [15:0] peer_mss     = '0;
  logic [31:0] echo_word    = '0;
  logic        seg_ack      = 1'b0;
  logic        seg_mss_new  = 1'b0;
  logic        seg_echo_new = 1'b0;
  logic        ts_enable    = 1'b0;

  // Closing a parse produces its one result and returns the walk to idle. Values stored
  // earlier in the segment are kept, even when the parse ends in an error.
  function automatic void end_parse(input status_e st);
    result_t r;
    r.status       = st;
    r.mss_value    = peer_mss;
    r.mss_updated  = seg_mss_new;
    r.echo_value   = echo_word;
    r.echo_updated = seg_echo_new;
    results_due.push_back(r);
    walk = WALK_IDLE;
  endfunction

  // Once an option has been fully consumed, the parse either ends cleanly at the end of the
  // area or looks for the next option kind.
  function automatic void option_finished();
    if (area_left == 6'd0) begin
      end_parse(ST_OK);
    end else begin
      walk = WALK_KIND;
    end
  endfunction

  // Steps the parser by one accepted word.
  function automatic void advance_parser(input in_word_t w);
    logic [7:0] b;
    b = w.opt_byte;
    if (w.kind == KIND_HDR) begin
      // A header always starts afresh, abandoning any parse that was still under way.
      seg_ack      = w.ack_bit;
      seg_mss_new  = 1'b0;
      seg_echo_new = 1'b0;
      cur_code     = '0;
      cur_len      = '0;
      body_pos     = '0;
      body_bits    = '0;
      if (w.data_offset < 4'd5) begin
        area_left = '0;
        end_parse(ST_TOO_SHORT);
      end else begin
        area_left = {w.data_offset, 2'b00} - 6'd20;
        if (area_left == 6'd0) begin
          end_parse(ST_OK);
        end else begin
          walk = WALK_KIND;
        end
      end
    end else begin
      case (walk)
        WALK_KIND: begin
          if (b == OPT_NOP) begin
            area_left = area_left - 6'd1;
            option_finished();
          end else if (b == OPT_EOL) begin
            end_parse(ST_OK);
          end else if (area_left < 6'd2) begin
            // The kind byte is the last byte of the area, so its length byte is missing.
            end_parse(ST_OVERRUN);
          end else begin
            cur_code = b;
            walk     = WALK_LEN;
          end
        end
        WALK_LEN: begin
          // The length counts the kind and length bytes, and the kind byte is still part of
          // the bytes left at this point.
          if (b < 8'd2) begin
            end_parse(ST_BAD_LEN);
          end else if (b > {2'b00, area_left}) begin
            end_parse(ST_OVERRUN);
          end else begin
            area_left = area_left - b[5:0];
            cur_len   = b;
            body_pos  = '0;
            body_bits = '0;
            if (b == 8'd2) begin
              option_finished();
            end else begin
              walk = WALK_BODY;
            end
          end
        end
        WALK_BODY: begin
          body_bits = {body_bits[23:0], b};
          if (cur_code == OPT_MSS && body_pos == 8'd1) begin
            peer_mss    = body_bits[15:0];
            seg_mss_new = 1'b1;
          end
          if (cur_code == OPT_TS && body_pos == 8'd3 && seg_ack && ts_enable) begin
            echo_word    = body_bits;
            seg_echo_new = 1'b1;
          end
          body_pos = body_pos + 8'd1;
          if ({1'b0, body_pos} + 9'd2 >= {1'b0, cur_len}) begin
            option_finished();
          end
        end
        default: begin
          // Option bytes while idle are ignored.
        end
      endcase
    end
  endfunction

  // Fields that the block ignores for a given word kind are still randomised, so that every
  // bit of every input field toggles.
  function automatic void add_hdr(input logic [3:0] doff, input logic ack);
    in_word_t w;
    w.kind        = KIND_HDR;
    w.data_offset = doff;
    w.ack_bit     = ack;
    w.opt_byte    = 8'($urandom);
    words_to_send.push_back(w);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    in_word_t w;
    w.kind        = KIND_OPT;
    w.data_offset = 4'($urandom);
    w.ack_bit     = 1'($urandom);
    w.opt_byte    = b;
    words_to_send.push_back(w);
  endfunction

  // Queues random segments until about the given number of words that the block acts upon
  // have been queued. Most segments carry well-formed options with random contents; the rest
  // are short headers, broken lengths, truncated segments and stray bytes.
  task automatic queue_random_words(input int target);
    int         counted;
    int         doff;
    int         left;
    int         pick;
    int         len;
    int         n;
    logic [7:0] code;
    counted = 0;
    while (counted < target) begin
      doff = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      add_hdr(4'(doff), 1'($urandom_range(0, 3) != 0));
      counted++;
      left = (doff >= 5) ? doff * 4 - 20 : 0;
      while (left > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          add_byte(OPT_NOP);
          left--;
          counted++;
        end else if (pick < 20) begin
          // End of the option list. The padding behind it reaches an idle parser and is
          // ignored, so it does not count.
          add_byte(OPT_EOL);
          counted++;
          repeat (left - 1) add_byte(8'($urandom));
          left = 0;
        end else if (pick < 23) begin
          // Truncated segment: the next header abandons the parse, possibly just after a
          // kind byte.
          if ($urandom_range(0, 1) == 1) begin
            add_byte(OPT_MSS);
            counted++;
          end
          left = 0;
        end else if (pick < 26) begin
          // Broken length: either below two or running past the end of the area.
          add_byte(8'($urandom_range(2, 255)));
          counted++;
          if (left >= 2) begin
            if ($urandom_range(0, 1) == 1) begin
              add_byte(8'($urandom_range(0, 1)));
            end else begin
              add_byte(8'($urandom_range(left + 1, 255)));
            end
            counted++;
          end
          left = 0;
        end else begin
          n    = $urandom_range(0, 9);
          code = (n < 4) ? OPT_MSS : (n < 8) ? OPT_TS : 8'($urandom_range(2, 255));
          if (left < 2) begin
            // A kind byte with no room left for its length byte.
            add_byte(code);
            counted++;
            left = 0;
          end else begin
            len = (code == OPT_MSS) ? 4 : (code == OPT_TS) ? 10 : $urandom_range(2, 12);
            // Now and then an odd length, giving short or over-long bodies.
            if ($urandom_range(0, 4) == 0) begin
              len = $urandom_range(2, 14);
            end
            if (len > left) begin
              len = left;
            end
            add_byte(code);
            add_byte(8'(len));
            repeat (len - 2) add_byte(8'($urandom));
            counted += len;
            left    -= len;
          end
        end
      end
      // Occasional stray option bytes between segments.
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
    end
  endtask

  // Waits until every queued word has been taken and every predicted result has arrived,
  // then lets the block settle. Only after this may the register be written.
  task automatic wait_until_quiet();
    while (words_to_send.size() != 0 || in_valid_i || word_taken || results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes the timestamps enable register through its own channel and hands the new value
  // to the predictor once the write has been accepted.
  task automatic write_ts_enable(input logic en);
    @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    timestamps_valid_i <= en;
    do @(posedge clk_i); while (!cfg_ready_s);
    cfg_valid_i <= 1'b0;
    ts_enable    = en;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("tb_tcp_option_parser_top: mismatch at cycle %0d: %s", cycle, what);
    end
  endtask

  // Falling edge: sample the outputs of the block and step the predictor by any word taken.
  always @(negedge clk_i) begin
    in_ready_s  <= in_ready_o;
    cfg_ready_s <= cfg_ready_o;
    out_valid_s <= out_valid_o;
    seen_result <= {status_o, mss_value_o, mss_updated_o, echo_value_o, echo_updated_o};
    if (word_taken) begin
      advance_parser(taken_word);
    end
  end

  // Input driver. A presented word is held unchanged until it is taken. Between words the
  // driver may idle for a burst of random length.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken <= in_valid_i && in_ready_s;
      taken_word <= {kind_i, data_offset_i, ack_bit_i, opt_byte_i};
      if (!in_valid_i || in_ready_s) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
          // This cycle is the first of the burst.
          gap_left = $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          {kind_i, data_offset_i, ack_bit_i, opt_byte_i} <= words_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result word taken is compared field by field with the oldest
  // prediction; the receiver stalls in bursts of random length.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_s && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word arrived with no result predicted");
        end else begin
          want = results_due.pop_front();
          if (seen_result.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      seen_result.status, want.status));
          if (seen_result.mss_value !== want.mss_value)
            report_mismatch($sformatf("mss_value 0x%04h, predicted 0x%04h",
                                      seen_result.mss_value, want.mss_value));
          if (seen_result.mss_updated !== want.mss_updated)
            report_mismatch($sformatf("mss_updated %0b, predicted %0b",
                                      seen_result.mss_updated, want.mss_updated));
          if (seen_result.echo_value !== want.echo_value)
            report_mismatch($sformatf("echo_value 0x%08h, predicted 0x%08h",
                                      seen_result.echo_value, want.echo_value));
          if (seen_result.echo_updated !== want.echo_updated)
            report_mismatch($sformatf("echo_updated %0b, predicted %0b",
                                      seen_result.echo_updated, want.echo_updated));
        end
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a run that hangs ends here as a failure.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("tb_tcp_option_parser_top: FAIL");
      $finish;
    end
  end

  initial begin
    // Reset is applied once, at the start of the run.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with timestamps enabled so that the echo path can be seen.
    write_ts_enable(1'b1);
    @(negedge clk_i);
    gap_pct   = 30;
    stall_pct = 30;
    // Header too short, at the lowest data offset.
    add_hdr(4'd0, 1'b0);
    // Empty option area.
    add_hdr(4'd5, 1'b1);
    // MSS option with the largest value.
    add_hdr(4'd6, 1'b1);
    add_byte(OPT_MSS);
    add_byte(8'd4);
    add_byte(8'hFF);
    add_byte(8'hFF);
    // Timestamp option with a four byte body, then end of list and a byte that is ignored.
    add_hdr(4'd7, 1'b1);
    add_byte(OPT_TS);
    add_byte(8'd6);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(OPT_EOL);
    add_byte(8'h55);
    // Length below two.
    add_hdr(4'd6, 1'b0);
    add_byte(8'd3);
    add_byte(8'd1);
    // Length beyond the option area.
    add_hdr(4'd6, 1'b1);
    add_byte(8'd5);
    add_byte(8'd7);
    // MSS with no body (stores nothing), a NOP, then a kind whose length byte is missing.
    add_hdr(4'd6, 1'b1);
    add_byte(OPT_MSS);
    add_byte(8'd2);
    add_byte(OPT_NOP);
    add_byte(8'd9);
    wait_until_quiet();

    // Random segments with timestamps disabled and moderate idling.
    write_ts_enable(1'b0);
    @(negedge clk_i);
    gap_pct   = 20;
    stall_pct = 20;
    queue_random_words(600);
    wait_until_quiet();

    // Random segments with timestamps enabled and heavy idling on both sides.
    write_ts_enable(1'b1);
    @(negedge clk_i);
    gap_pct   = 50;
    stall_pct = 50;
    queue_random_words(600);
    wait_until_quiet();

    // Final stretch at full rate with no idling on either side.
    write_ts_enable(1'b1);
    @(negedge clk_i);
    calm = 1'b1;
    queue_random_words(650);
    wait_until_quiet();

    if (mismatches == 0) begin
      $display("tb_tcp_option_parser_top: PASS");
    end else begin
      $display("tb_tcp_option_parser_top: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/tcpop_pkg.sv
hdl/tcpop_in_stage.sv
hdl/tcpop_core.sv
hdl/tcpop_out_stage.sv
hdl/tcp_option_parser_top.sv
test/tb_tcp_option_parser_top.sv
